### sv/l2u_pkg.sv
// Shared types, constants and the Latin-2 letter table for the quoted UTF-8 encoder.
`default_nettype none
package l2u_pkg;

    localparam int unsigned NumChars   = 6;
    localparam int unsigned CountWidth = $clog2(NumChars + 1);

    localparam logic [7:0] CharEquals  = 8'h3D;
    localparam logic [7:0] CharZero    = 8'h30;
    localparam logic [7:0] CharAlphaLo = 8'h37;  // 'A' - 10
    localparam logic [8:0] Utf8Lead    = 9'h080;

    typedef logic [8:0] code_point_t;

    typedef struct packed {
        logic [CountWidth-1:0]        count;
        logic [NumChars-1:0][7:0]     chars;  // chars[0] leaves first
    } enc_t;

    function automatic code_point_t to_code_point(input logic [7:0] b);
        code_point_t cp;
        case (b)
            8'hC8: cp = 9'h10C;
            8'hCF: cp = 9'h10E;
            8'hCC: cp = 9'h11A;
            8'hD2: cp = 9'h147;
            8'hD8: cp = 9'h158;
            8'hA9: cp = 9'h160;
            8'hAB: cp = 9'h164;
            8'hD9: cp = 9'h16E;
            8'hAE: cp = 9'h17D;
            8'hE8: cp = 9'h10D;
            8'hEF: cp = 9'h10F;
            8'hEC: cp = 9'h11B;
            8'hF2: cp = 9'h148;
            8'hF8: cp = 9'h159;
            8'hB9: cp = 9'h161;
            8'hBB: cp = 9'h165;
            8'hF9: cp = 9'h16F;
            8'hBE: cp = 9'h17E;
            8'hC3: cp = 9'h102;
            8'hA1: cp = 9'h104;
            8'hC6: cp = 9'h106;
            8'hD0: cp = 9'h110;
            8'hCA: cp = 9'h118;
            8'hA5: cp = 9'h13D;
            8'hC5: cp = 9'h139;
            8'hA3: cp = 9'h141;
            8'hD1: cp = 9'h143;
            8'hD5: cp = 9'h150;
            8'hC0: cp = 9'h154;
            8'hA6: cp = 9'h15A;
            8'hAA: cp = 9'h15E;
            8'hDE: cp = 9'h162;
            8'hDB: cp = 9'h170;
            8'hAC: cp = 9'h179;
            8'hAF: cp = 9'h17B;
            8'hE3: cp = 9'h103;
            8'hB1: cp = 9'h105;
            8'hE6: cp = 9'h107;
            8'hF0: cp = 9'h111;
            8'hEA: cp = 9'h119;
            8'hB5: cp = 9'h13E;
            8'hE5: cp = 9'h13A;
            8'hB3: cp = 9'h142;
            8'hF1: cp = 9'h144;
            8'hF5: cp = 9'h151;
            8'hE0: cp = 9'h155;
            8'hB6: cp = 9'h15B;
            8'hBA: cp = 9'h15F;
            8'hFE: cp = 9'h163;
            8'hFB: cp = 9'h171;
            8'hBC: cp = 9'h17A;
            8'hBF: cp = 9'h17C;
            default: cp = {1'b0, b};
        endcase
        return cp;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        logic [7:0] base;
        base = (nibble < 4'd10) ? CharZero : CharAlphaLo;
        return base + {4'h0, nibble};
    endfunction

endpackage
`default_nettype wire

### sv/l2u_char_map.sv
// Maps one Latin-2 byte to its output text: the raw byte or six '=XX=XX' characters.
`default_nettype none
module l2u_char_map (
    input  wire logic [7:0] in_byte,
    output l2u_pkg::enc_t   enc
);

    l2u_pkg::code_point_t cp;
    logic [7:0]           b1;
    logic [7:0]           b2;

    always_comb
    begin
        cp = l2u_pkg::to_code_point(in_byte);
        b1 = 8'hC0 | {5'b00000, cp[8:6]};
        b2 = {2'b10, cp[5:0]};
        if (cp < l2u_pkg::Utf8Lead)
        begin
            enc.count    = l2u_pkg::CountWidth'(1);
            enc.chars    = '0;
            enc.chars[0] = in_byte;
        end
        else
        begin
            enc.count    = l2u_pkg::CountWidth'(l2u_pkg::NumChars);
            enc.chars[0] = l2u_pkg::CharEquals;
            enc.chars[1] = l2u_pkg::hex_char(b1[7:4]);
            enc.chars[2] = l2u_pkg::hex_char(b1[3:0]);
            enc.chars[3] = l2u_pkg::CharEquals;
            enc.chars[4] = l2u_pkg::hex_char(b2[7:4]);
            enc.chars[5] = l2u_pkg::hex_char(b2[3:0]);
        end
    end

endmodule
`default_nettype wire

### sv/latin2_to_quoted_utf8_encoder.sv
// Top level of the Latin-2 to quoted UTF-8 encoder: input register and output shifter.
//
//   channel | direction | handshake          | payload
//   in      | into      | in_valid/in_ready  | in_byte, in_last
//   out     | out of    | out_valid/out_ready| out_byte, out_run_end, out_string_end
//
// A request that maps below 0x80 leaves as one byte, one per cycle back to back while out_ready is high.
// A mapped letter or high byte leaves as six bytes, shifted out by the output shifter.
// One request waits in the input register while the shifter drains; once it is full,
// a six-byte run holds in_ready low until the last byte of the run is taken.
// rst_n clears both valid flags at once; payload registers are not reset.
`default_nettype none
module latin2_to_quoted_utf8_encoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_run_end,
    output logic            out_string_end
);

    logic                                  s1_valid_reg;
    logic [7:0]                            s1_byte_reg;
    logic                                  s1_last_reg;
    logic [l2u_pkg::CountWidth-1:0]        rem_reg;
    logic [l2u_pkg::CountWidth-1:0]        rem_next;
    logic [l2u_pkg::NumChars-1:0][7:0]     chars_reg;
    logic [l2u_pkg::NumChars-1:0][7:0]     chars_next;
    logic                                  last_reg;

    l2u_pkg::enc_t enc;
    logic          pop;
    logic          s2_free;
    logic          load;
    logic          in_take;

    l2u_char_map u_map (
        .in_byte (s1_byte_reg),
        .enc     (enc)
    );

    assign out_valid      = (rem_reg != '0);
    assign out_byte       = chars_reg[0];
    assign out_run_end    = (rem_reg == l2u_pkg::CountWidth'(1));
    assign out_string_end = out_run_end & last_reg;

    assign pop      = out_valid & out_ready;
    assign s2_free  = !out_valid || (pop && out_run_end);
    assign load     = s1_valid_reg & s2_free;
    assign in_ready = !s1_valid_reg || load;
    assign in_take  = in_valid & in_ready;

    always_comb
    begin
        rem_next   = rem_reg;
        chars_next = chars_reg;
        if (load)
        begin
            rem_next   = enc.count;
            chars_next = enc.chars;
        end
        else if (pop)
        begin
            rem_next   = rem_reg - l2u_pkg::CountWidth'(1);
            chars_next = {8'h00, chars_reg[l2u_pkg::NumChars-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            rem_reg      <= '0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (load)
                s1_valid_reg <= 1'b0;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
        if (load)
            last_reg <= s1_last_reg;
        chars_reg <= chars_next;
    end

endmodule
`default_nettype wire
